FILE: rtl/rdd_pkg.sv
`timescale 1ns / 1ps

package rdd_pkg;

    // Stream field widths
    localparam int ACTION_W   = 2;
    localparam int PIDX_W     = 4;
    localparam int RIDX_W     = 3;
    localparam int AMOUNT_W   = 8;
    localparam int MASK_W     = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // Input tdata bit positions
    localparam int PIDX_LSB   = 0;
    localparam int RIDX_LSB   = PIDX_LSB + PIDX_W;
    localparam int AMOUNT_LSB = RIDX_LSB + RIDX_W;

    // Configuration registers
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int PCOUNT_W    = 5;
    localparam int RCOUNT_W    = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESOURCE_COUNT = 1'b1;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;
    localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = 4'd8;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_PROCESSES = 16;
    localparam int DEF_MAX_RESOURCES = 8;
    localparam int DEF_AMOUNT_BITS   = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_ALLOC = 2'd0,
        ACT_LOAD_REQ   = 2'd1,
        ACT_LOAD_AVAIL = 2'd2,
        ACT_RUN        = 2'd3
    } action_t;

    typedef struct packed {
        action_t               kind;
        logic [PIDX_W-1:0]     pidx;
        logic [RIDX_W-1:0]     ridx;
        logic [AMOUNT_W-1:0]   amount;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROC,
        ST_REQ,
        ST_ADD,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic clearing;
        logic running;
    } back_status_t;

endpackage

FILE: rtl/rdd_front.sv
`timescale 1ns / 1ps

module rdd_front #(
    parameter int MAX_PROCESSES = rdd_pkg::DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = rdd_pkg::DEF_MAX_RESOURCES
) (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rdd_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [rdd_pkg::ACTION_W-1:0] s_tuser,
    input  logic                         q_full,
    output logic                         push,
    output rdd_pkg::cmd_t                cmd
);
    import rdd_pkg::*;

    logic keep;

    always_comb
    begin
        cmd.kind   = action_t'(s_tuser);
        cmd.pidx   = s_tdata[PIDX_LSB +: PIDX_W];
        cmd.ridx   = s_tdata[RIDX_LSB +: RIDX_W];
        cmd.amount = s_tdata[AMOUNT_LSB +: AMOUNT_W];
    end

    // Drop loads that point outside the stores; they are still taken
    always_comb
    begin
        unique case (cmd.kind)
            ACT_LOAD_ALLOC, ACT_LOAD_REQ:
                keep = (int'(cmd.pidx) < MAX_PROCESSES) && (int'(cmd.ridx) < MAX_RESOURCES);
            ACT_LOAD_AVAIL:
                keep = int'(cmd.ridx) < MAX_RESOURCES;
            ACT_RUN:
                keep = 1'b1;
            default:
                keep = 1'b0;
        endcase
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full && keep;

endmodule

FILE: rtl/rdd_queue.sv
`timescale 1ns / 1ps

module rdd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rdd_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          q_valid,
    output rdd_pkg::cmd_t q_cmd,
    input  logic          pop
);
    import rdd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/rdd_back.sv
`timescale 1ns / 1ps

module rdd_back #(
    parameter int MAX_PROCESSES = rdd_pkg::DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = rdd_pkg::DEF_MAX_RESOURCES,
    parameter int AMOUNT_BITS   = rdd_pkg::DEF_AMOUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rdd_pkg::PCOUNT_W-1:0]  process_count,
    input  logic [rdd_pkg::RCOUNT_W-1:0]  resource_count,
    input  logic                          q_valid,
    input  rdd_pkg::cmd_t                 q_cmd,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rdd_pkg::MASK_W-1:0]    deadlocked_mask,
    output logic                          deadlock_found,
    output rdd_pkg::back_status_t         status
);
    import rdd_pkg::*;

    localparam int PIW       = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RIW       = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCW       = $clog2(MAX_PROCESSES + 1);
    localparam int RCW       = $clog2(MAX_RESOURCES + 1);
    localparam int MEM_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int WW        = AMOUNT_BITS + $clog2(MAX_PROCESSES + 1);
    localparam int EXT_W     = (MAX_PROCESSES > MASK_W) ? MAX_PROCESSES : MASK_W;

    back_state_t state_reg;
    back_state_t state_next;

    logic [AMOUNT_BITS-1:0] alloc_mem [MEM_DEPTH];
    logic [AMOUNT_BITS-1:0] req_mem   [MEM_DEPTH];
    logic [AMOUNT_BITS-1:0] alloc_rd_reg;
    logic [AMOUNT_BITS-1:0] req_rd_reg;

    logic [AMOUNT_BITS-1:0] avail_reg [MAX_RESOURCES];
    logic [WW-1:0]          work_reg  [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] fin_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic [PCW-1:0]         p_reg;
    logic [RCW-1:0]         r_reg;
    logic                   progress_reg;
    logic                   out_valid_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic                   found_reg;

    logic [PCW-1:0]         nproc;
    logic [RCW-1:0]         nres;
    logic [AMOUNT_BITS-1:0] cmd_amt;
    logic [AW-1:0]          cmd_addr;
    logic [PIW-1:0]         p_idx;
    logic [RIW-1:0]         r_idx;
    logic [RCW-1:0]         r_inc;
    logic                   r_last;
    logic                   pass_end;
    logic                   req_gt;
    logic                   clr_last;
    logic                   alloc_we;
    logic                   req_we;
    logic [AW-1:0]          wr_addr;
    logic [AMOUNT_BITS-1:0] wr_data;
    logic [RIW-1:0]         rd_r;
    logic [AW-1:0]          rd_addr;
    logic                   result_load;
    logic [MAX_PROCESSES-1:0] stuck;
    logic [EXT_W-1:0]       stuck_ext;

    // Clamp the counts to what the stores hold
    always_comb
    begin
        if (int'(process_count) > MAX_PROCESSES)
            nproc = PCW'(MAX_PROCESSES);
        else
            nproc = PCW'(process_count);
        if (int'(resource_count) > MAX_RESOURCES)
            nres = RCW'(MAX_RESOURCES);
        else
            nres = RCW'(resource_count);
    end

    // Keep only the low AMOUNT_BITS of the load value
    always_comb
    begin
        cmd_amt = '0;
        for (int b = 0; b < AMOUNT_BITS && b < AMOUNT_W; b++)
            cmd_amt[b] = q_cmd.amount[b];
    end

    assign cmd_addr = AW'(int'(PIW'(q_cmd.pidx)) * MAX_RESOURCES + int'(RIW'(q_cmd.ridx)));
    assign p_idx    = p_reg[PIW-1:0];
    assign r_idx    = r_reg[RIW-1:0];
    assign r_inc    = r_reg + 1'b1;
    assign r_last   = (r_inc == nres);
    assign pass_end = (p_reg == nproc);
    assign req_gt   = WW'(req_rd_reg) > work_reg[r_idx];
    assign clr_last = (clr_addr_reg == AW'(MEM_DEPTH - 1));
    assign rd_addr  = AW'(int'(p_idx) * MAX_RESOURCES + int'(rd_r));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid && q_cmd.kind == ACT_RUN)
                    state_next = ST_PROC;
            ST_PROC:
                priority if (pass_end)
                    state_next = progress_reg ? ST_PROC : ST_DONE;
                else if (fin_reg[p_idx] || nres == '0)
                    state_next = ST_PROC;
                else
                    state_next = ST_REQ;
            ST_REQ:
                priority if (req_gt)
                    state_next = ST_PROC;
                else if (r_last)
                    state_next = ST_ADD;
                else
                    state_next = ST_REQ;
            ST_ADD:
                if (r_last)
                    state_next = ST_PROC;
            ST_DONE:
                if (result_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        pop         = 1'b0;
        alloc_we    = 1'b0;
        req_we      = 1'b0;
        wr_addr     = cmd_addr;
        wr_data     = cmd_amt;
        rd_r        = '0;
        result_load = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                alloc_we = 1'b1;
                req_we   = 1'b1;
                wr_addr  = clr_addr_reg;
                wr_data  = '0;
            end
            ST_IDLE:
            begin
                pop      = q_valid;
                alloc_we = q_valid && q_cmd.kind == ACT_LOAD_ALLOC;
                req_we   = q_valid && q_cmd.kind == ACT_LOAD_REQ;
            end
            ST_PROC:
                rd_r = '0;
            ST_REQ:
                rd_r = r_last ? '0 : r_inc[RIW-1:0];
            ST_ADD:
                rd_r = r_inc[RIW-1:0];
            ST_DONE:
                result_load = !out_valid_reg || m_tready;
            default:
                rd_r = '0;
        endcase
    end

    // Matrix stores: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (alloc_we)
            alloc_mem[wr_addr] <= wr_data;
        alloc_rd_reg <= alloc_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req_we)
            req_mem[wr_addr] <= wr_data;
        req_rd_reg <= req_mem[rd_addr];
    end

    // Processes in use that never finished
    always_comb
    begin
        for (int i = 0; i < MAX_PROCESSES; i++)
            stuck[i] = (i < int'(nproc)) && !fin_reg[i];
    end

    assign stuck_ext = EXT_W'(stuck);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            p_reg         <= '0;
            r_reg         <= '0;
            progress_reg  <= 1'b0;
            fin_reg       <= '0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            found_reg     <= 1'b0;
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                avail_reg[i] <= '0;
                work_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLEAR:
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                ST_IDLE:
                    if (q_valid)
                    begin
                        unique case (q_cmd.kind)
                            ACT_LOAD_AVAIL:
                                avail_reg[RIW'(q_cmd.ridx)] <= cmd_amt;
                            ACT_RUN:
                            begin
                                for (int i = 0; i < MAX_RESOURCES; i++)
                                    work_reg[i] <= WW'(avail_reg[i]);
                                fin_reg      <= '0;
                                p_reg        <= '0;
                                progress_reg <= 1'b0;
                            end
                            ACT_LOAD_ALLOC, ACT_LOAD_REQ:
                                ;
                            default:
                                ;
                        endcase
                    end
                ST_PROC:
                    priority if (pass_end)
                    begin
                        if (progress_reg)
                        begin
                            p_reg        <= '0;
                            progress_reg <= 1'b0;
                        end
                    end
                    else if (fin_reg[p_idx])
                        p_reg <= p_reg + 1'b1;
                    else if (nres == '0)
                    begin
                        // no resource in use: every request is met
                        fin_reg[p_idx] <= 1'b1;
                        progress_reg   <= 1'b1;
                        p_reg          <= p_reg + 1'b1;
                    end
                    else
                        r_reg <= '0;
                ST_REQ:
                    priority if (req_gt)
                        p_reg <= p_reg + 1'b1;
                    else if (r_last)
                        r_reg <= '0;
                    else
                        r_reg <= r_inc;
                ST_ADD:
                begin
                    work_reg[r_idx] <= work_reg[r_idx] + WW'(alloc_rd_reg);
                    if (r_last)
                    begin
                        fin_reg[p_idx] <= 1'b1;
                        progress_reg   <= 1'b1;
                        p_reg          <= p_reg + 1'b1;
                    end
                    else
                        r_reg <= r_inc;
                end
                ST_DONE:
                    ;
                default:
                    ;
            endcase

            if (result_load)
            begin
                out_valid_reg <= 1'b1;
                mask_reg      <= stuck_ext[MASK_W-1:0];
                found_reg     <= |stuck;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign deadlocked_mask = mask_reg;
    assign deadlock_found  = found_reg;

    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.running  = (state_reg == ST_PROC) || (state_reg == ST_REQ)
                          || (state_reg == ST_ADD) || (state_reg == ST_DONE);

endmodule

FILE: rtl/resource_deadlock_detector_top.sv
`timescale 1ns / 1ps

// Deadlock detector over an allocation matrix, a request matrix and an
// available-resource vector. Each request on the slave stream (its action
// in tuser) either loads one entry (allocation, request or available) or
// starts a detection run; loads give no response, a run gives one response
// with the mask of processes that never finish and a deadlock flag. The
// executor takes loads while idle, so loads stream at one per cycle when
// no run or clearing is under way. A run is carried out by a sequencer
// that walks the matrix stores one entry per cycle through one registered
// read port per store. Each pass visits every process in use; one not yet
// finished compares its requests with the work vector resource by
// resource and, when it can finish, adds its allocations to the work
// vector. Passes repeat until one makes no progress (at most
// process_count + 1 passes, counts taken after saturation); the result
// then goes to the output register, held back while an earlier response
// still waits there. Requests keep flowing into a two-entry queue during
// a run and stall once it fills. After reset the matrix stores are zeroed,
// one entry per cycle, all MAX_PROCESSES * MAX_RESOURCES (128 by default)
// of them, before the first request is executed; configuration writes are
// taken at any time and should be made only while the block is idle.

module resource_deadlock_detector_top #(
    parameter int MAX_PROCESSES = rdd_pkg::DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = rdd_pkg::DEF_MAX_RESOURCES,
    parameter int AMOUNT_BITS   = rdd_pkg::DEF_AMOUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [rdd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rdd_pkg::CFG_DATA_W-1:0]  cfg_data,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // from bit 0: process_index[3:0], resource_index[6:4], amount[14:7],
    // zero fill
    input  logic [rdd_pkg::IN_DATA_W-1:0]   s_tdata,
    // from bit 0: action[1:0]
    input  logic [rdd_pkg::ACTION_W-1:0]    s_tuser,
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // from bit 0: deadlocked_mask[15:0], deadlock_found[16], zero fill
    output logic [rdd_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import rdd_pkg::*;

    logic [PCOUNT_W-1:0] process_count_reg;
    logic [RCOUNT_W-1:0] resource_count_reg;

    logic         push;
    cmd_t         push_cmd;
    logic         q_full;
    logic         q_valid;
    cmd_t         q_cmd;
    logic         pop;
    logic [MASK_W-1:0] deadlocked_mask;
    logic         deadlock_found;
    back_status_t status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_count_reg  <= PCOUNT_RESET;
            resource_count_reg <= RCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROCESS_COUNT:
                    process_count_reg <= cfg_data[PCOUNT_W-1:0];
                CFG_RESOURCE_COUNT:
                    resource_count_reg <= cfg_data[RCOUNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Front: take requests, drop out-of-range loads
    rdd_front #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Queue: lets intake run ahead of the executor
    rdd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    // Back: stores, detection sequencer and output register
    rdd_back #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .AMOUNT_BITS   (AMOUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .process_count   (process_count_reg),
        .resource_count  (resource_count_reg),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .pop             (pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .deadlocked_mask (deadlocked_mask),
        .deadlock_found  (deadlock_found),
        .status          (status)
    );

    assign m_tdata = {{(OUT_DATA_W - MASK_W - 1){1'b0}}, deadlock_found, deadlocked_mask};

`ifndef SYNTHESIS
    // never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !push)
        else $error("push into full command queue");

    // never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) !q_valid |-> !pop)
        else $error("pop from empty command queue");

    // the executor takes no request while clearing or running
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.clearing || status.running) |-> !pop)
        else $error("request taken while executor busy");

    // no response before the stores are cleared
    assert property (@(posedge clk) disable iff (!rst_n) status.clearing |-> !m_tvalid)
        else $error("response during clearing pass");
`endif

endmodule
